// ===== rtl/ccw_pkg.sv =====
// Shared constants, types and the cell address function for the console cell writer.
package ccw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_XW = COL_W + 1;
  localparam int ROW_XW = ROW_W + 1;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int RCNT_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [3:0] DEFAULT_TAB  = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_STEP  = 2'd2;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_REWIND = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_REWIND,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic       enabled;
    logic [7:0] text_attr;
    logic [3:0] tab_step;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // visible row -> physical row through the ring origin, then row * COLS + col
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] vrow,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_XW-1:0] sum;
    logic [ROW_XW-1:0] prow;
    sum = {1'b0, top} + {1'b0, vrow};
    if (sum >= ROW_XW'(ROWS)) begin
      prow = sum - ROW_XW'(ROWS);
    end else begin
      prow = sum;
    end
    return ADDR_W'(ADDR_W'(prow[ROW_W-1:0]) * ADDR_W'(COLS)) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/ccw_ram.sv =====
// Simple dual-port synchronous RAM, registered read data.
module ccw_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ccw_ctrl.sv =====
// Cursor state, action sequencer and cell address generation.
module ccw_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ccw_pkg::cfg_t                 cfg,
  input  logic [1:0]                    in_action,
  input  logic [7:0]                    in_char_code,
  input  logic [ccw_pkg::RCNT_W-1:0]    in_rewind_count,
  input  logic                          in_erase,
  input  logic [4:0]                    in_read_row,
  input  logic [6:0]                    in_read_col,
  output ccw_pkg::mem_req_t             mem_req,
  input  logic [ccw_pkg::CELL_W-1:0]    mem_rdata,
  output logic                          out_valid,
  output logic [ccw_pkg::OUT_COL_W-1:0] out_cursor_col,
  output logic [ccw_pkg::OUT_ROW_W-1:0] out_cursor_row,
  output logic [7:0]                    out_read_char,
  output logic [7:0]                    out_read_attr,
  output logic                          out_scrolled
);
  import ccw_pkg::*;

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    line_r, line_nxt;
  logic [ROW_W-1:0]    top_r, top_nxt;
  logic [ADDR_W-1:0]   fill_addr_r, fill_addr_nxt;
  logic [7:0]          fill_attr_r, fill_attr_nxt;
  logic [RCNT_W-1:0]   rew_r, rew_nxt;
  logic                erase_r, erase_nxt;
  logic [COL_W-1:0]    wcnt_r, wcnt_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_COL_W-1:0] out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [7:0]          out_rchar_r, out_rchar_nxt;
  logic [7:0]          out_rattr_r, out_rattr_nxt;
  logic                out_scr_r, out_scr_nxt;

  action_t             act;
  logic                accept;
  logic                read_ok;
  logic [COL_XW-1:0]   put_col_x;
  logic [ROW_XW-1:0]   put_line_x;
  logic                put_write;
  logic                put_scroll;
  logic                rew_go;
  logic [COL_W-1:0]    col_dec;
  logic                fill_last;
  logic                emit;
  logic [7:0]          rchar_v;
  logic [7:0]          rattr_v;
  logic                scr_v;

  assign act     = action_t'(in_action);
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign read_ok = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLS);
  assign rew_go  = (col_r != '0) && (in_rewind_count != '0);
  assign col_dec = col_r - COL_W'(1);
  assign fill_last = (fill_addr_r == ADDR_W'(CELLS - 1));

  // put-char cursor update
  always_comb begin
    put_col_x  = {1'b0, col_r};
    put_line_x = {1'b0, line_r};
    put_write  = 1'b0;
    if (in_char_code == CH_NEWLINE) begin
      put_col_x  = '0;
      put_line_x = put_line_x + ROW_XW'(1);
    end else if (in_char_code == CH_TAB) begin
      put_col_x = put_col_x + COL_XW'(cfg.tab_step);
    end else begin
      put_col_x = put_col_x + COL_XW'(1);
      put_write = 1'b1;
    end
    if (put_col_x >= COL_XW'(COLS)) begin
      put_col_x  = '0;
      put_line_x = put_line_x + ROW_XW'(1);
    end
    put_scroll = (put_line_x >= ROW_XW'(ROWS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_READ:   state_nxt = ST_READ;
            ACT_PUT:    if (cfg.enabled && put_scroll) state_nxt = ST_SCROLL;
            ACT_REWIND: if (cfg.enabled && rew_go) state_nxt = ST_REWIND;
            ACT_CLEAR:  if (cfg.enabled) state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (wcnt_r == COL_W'(COLS - 1)) state_nxt = ST_IDLE;
      end
      ST_REWIND: begin
        if (rew_r == RCNT_W'(1)) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (fill_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory requests and result
  always_comb begin
    col_nxt       = col_r;
    line_nxt      = line_r;
    top_nxt       = top_r;
    fill_addr_nxt = fill_addr_r;
    fill_attr_nxt = fill_attr_r;
    rew_nxt       = rew_r;
    erase_nxt     = erase_r;
    wcnt_nxt      = wcnt_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_rchar_nxt = out_rchar_r;
    out_rattr_nxt = out_rattr_r;
    out_scr_nxt   = out_scr_r;
    mem_req       = '0;
    emit          = 1'b0;
    rchar_v       = '0;
    rattr_v       = '0;
    scr_v         = 1'b0;

    case (state_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr_r;
        mem_req.wdata = {fill_attr_r, BLANK_CHAR};
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
      end
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr_r;
        mem_req.wdata = {fill_attr_r, BLANK_CHAR};
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        emit          = fill_last;
      end
      ST_IDLE: begin
        if (accept) begin
          fill_attr_nxt = cfg.text_attr;
          case (act)
            ACT_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cell_addr(top_r, ROW_W'(in_read_row), COL_W'(in_read_col));
              rd_ok_nxt     = read_ok;
            end
            ACT_PUT: begin
              if (cfg.enabled) begin
                if (put_write) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cell_addr(top_r, line_r, col_r);
                  mem_req.wdata = {cfg.text_attr, in_char_code};
                end
                if (put_scroll) begin
                  // old origin row becomes the new bottom line
                  top_nxt       = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
                  fill_addr_nxt = cell_addr(top_r, '0, '0);
                  wcnt_nxt      = '0;
                  col_nxt       = '0;
                  line_nxt      = ROW_W'(ROWS - 1);
                end else begin
                  col_nxt  = put_col_x[COL_W-1:0];
                  line_nxt = put_line_x[ROW_W-1:0];
                  emit     = 1'b1;
                end
              end else begin
                emit = 1'b1;
              end
            end
            ACT_REWIND: begin
              if (cfg.enabled && rew_go) begin
                rew_nxt   = in_rewind_count;
                erase_nxt = in_erase;
              end else begin
                emit = 1'b1;
              end
            end
            ACT_CLEAR: begin
              if (cfg.enabled) begin
                col_nxt       = '0;
                line_nxt      = '0;
                top_nxt       = '0;
                fill_addr_nxt = '0;
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        emit = 1'b1;
        if (rd_ok_r) begin
          rchar_v = mem_rdata[7:0];
          rattr_v = mem_rdata[15:8];
        end
      end
      ST_SCROLL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr_r;
        mem_req.wdata = {fill_attr_r, BLANK_CHAR};
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        wcnt_nxt      = wcnt_r + COL_W'(1);
        if (wcnt_r == COL_W'(COLS - 1)) begin
          emit  = 1'b1;
          scr_v = 1'b1;
        end
      end
      ST_REWIND: begin
        if (erase_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cell_addr(top_r, line_r, col_dec);
          mem_req.wdata = {fill_attr_r, BLANK_CHAR};
        end
        // column 0 is never left standing: wrap to the end of the line above (row 0 stays on row 0)
        if (col_dec == '0) begin
          col_nxt  = COL_W'(COLS - 1);
          line_nxt = (line_r != '0) ? line_r - ROW_W'(1) : line_r;
        end else begin
          col_nxt = col_dec;
        end
        rew_nxt = rew_r - RCNT_W'(1);
        emit    = (rew_r == RCNT_W'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = OUT_COL_W'(col_nxt);
      out_row_nxt   = OUT_ROW_W'(line_nxt);
      out_rchar_nxt = rchar_v;
      out_rattr_nxt = rattr_v;
      out_scr_nxt   = scr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      line_r      <= '0;
      top_r       <= '0;
      fill_addr_r <= '0;
      fill_attr_r <= DEFAULT_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      top_r       <= top_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_attr_r <= fill_attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rew_r       <= rew_nxt;
    erase_r     <= erase_nxt;
    wcnt_r      <= wcnt_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_rchar_r <= out_rchar_nxt;
    out_rattr_r <= out_rattr_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_read_char  = out_rchar_r;
  assign out_read_attr  = out_rattr_r;
  assign out_scrolled   = out_scr_r;

endmodule

// ===== rtl/text_console_cell_writer.sv =====
// Text console cell writer: top level with configuration registers and the cell store.
// A command is taken when start is high and busy is low; its result beat appears on
// the out_ ports for one cycle with out_valid, in the cycle after the work ends, and
// cannot be held off. Work is set by the single write port of the 2000-cell store:
// put writes at most one cell (and blanks the 80 cells of the new bottom line when it
// scrolls), read fetches one cell, rewind steps back once per count (erasing each cell
// if asked), clear blanks every cell, and a disabled action writes nothing. After reset
// busy stays high while the store is blanked; configuration writes are taken during it.
module text_console_cell_writer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_action,
  input  logic [7:0]                       in_char_code,
  input  logic [11:0]                      in_rewind_count,
  input  logic                             in_erase,
  input  logic [4:0]                       in_read_row,
  input  logic [6:0]                       in_read_col,
  output logic                             out_valid,
  output logic [6:0]                       out_cursor_col,
  output logic [4:0]                       out_cursor_row,
  output logic [7:0]                       out_read_char,
  output logic [7:0]                       out_read_attr,
  output logic                             out_scrolled,
  input  logic                             cfg_we,
  input  logic [ccw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ccw_pkg::*;

  logic              enabled_r, enabled_nxt;
  logic [7:0]        text_attr_r, text_attr_nxt;
  logic [3:0]        tab_step_r, tab_step_nxt;
  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;

  always_comb begin
    enabled_nxt   = enabled_r;
    text_attr_nxt = text_attr_r;
    tab_step_nxt  = tab_step_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:   enabled_nxt   = cfg_wdata[0];
        REG_TEXT_ATTR: text_attr_nxt = cfg_wdata[7:0];
        REG_TAB_STEP:  tab_step_nxt  = cfg_wdata[3:0];
        default:       enabled_nxt   = enabled_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      text_attr_r <= DEFAULT_ATTR;
      tab_step_r  <= DEFAULT_TAB;
    end else begin
      enabled_r   <= enabled_nxt;
      text_attr_r <= text_attr_nxt;
      tab_step_r  <= tab_step_nxt;
    end
  end

  assign cfg = '{enabled: enabled_r, text_attr: text_attr_r, tab_step: tab_step_r};

  ccw_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .cfg            (cfg),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_rewind_count(in_rewind_count),
    .in_erase       (in_erase),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .out_scrolled   (out_scrolled)
  );

  ccw_ram #(
    .DATA_W(CELL_W),
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

endmodule
